FILE: src/etr_pkg.sv
// shared types, codes and constants of the escaped frame transmitter ring
package etr_pkg;

    localparam int RING_DEPTH_DEF = 1024;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;

    // operation codes on the input channel
    typedef enum logic [2:0] {
        OP_BEGIN_FRAME = 3'd0,
        OP_PAYLOAD     = 3'd1,
        OP_END         = 3'd2,
        OP_BEGIN_RAW   = 3'd3,
        OP_TICK        = 3'd4
    } op_code_t;

    // decoded command kinds handed from front to back
    typedef enum logic [2:0] {
        CMD_NOP       = 3'd0,
        CMD_BEGIN_ESC = 3'd1,
        CMD_BEGIN_RAW = 3'd2,
        CMD_PAYLOAD   = 3'd3,
        CMD_END       = 3'd4,
        CMD_TICK      = 3'd5
    } cmd_kind_t;

    typedef enum logic [1:0] {
        FS_NONE    = 2'd0,
        FS_COMMIT  = 2'd1,
        FS_DISCARD = 2'd2
    } frame_status_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic       special;  // byte is a flag or escape code
        logic [7:0] data;
    } cmd_t;

endpackage

FILE: src/escaped_frame_tx_ring.sv
// Escaped frame transmitter with a byte ring: front decode, command queue, ring back end.
//
// Input requests arrive on s_tvalid/s_tready with the operation in s_tuser and the
// payload byte in s_tdata. Each request gives exactly one result on m_tvalid/m_tready:
// m_tdata is the byte sent on a tick (zero otherwise), m_tuser carries out_valid,
// the frame status (none, committed, discarded) and the ring empty flag.
// Escaped frames are stored as flag, stuffed payload, flag; raw blocks go in as is.
// Bytes of an open frame stay hidden from ticks until the frame is closed.
// A four-entry command queue separates decode from the ring, so requests keep being
// taken while the ring unit is busy or the result waits.
// The ring unit writes the ring entries of a request (one to three) one after another
// and passes a tick that reads the ring through a read state, since the ring memory
// has one port; it takes no new command from the queue until it is back in idle.
// Reset clears pointers, counts and frame state; ring contents are not cleared.
// When the receiver stalls the result register holds, the queue fills and s_tready
// drops once four requests are waiting.
module escaped_frame_tx_ring #(
    parameter int RING_DEPTH = etr_pkg::RING_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte
    input  logic [2:0] s_tuser,   // operation
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic [3:0] m_tuser    // out_valid, frame_status[1:0], ring_empty
);
    import etr_pkg::*;

    logic q_full, q_push, q_pop, q_not_empty;
    cmd_t push_cmd, pop_cmd;

    etr_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    etr_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_cmd   (pop_cmd)
    );

    etr_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_not_empty),
        .q_cmd    (pop_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    // a result with no byte sent carries a zero byte
    a_idle_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'h00)
        else $error("byte present without out_valid");

    // a sent byte never comes with a frame status
    a_tick_no_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tuser[2:1] == FS_NONE && !m_tuser[3] || m_tuser[2:1] == FS_NONE)
        else $error("tick result carries frame status");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
`endif

endmodule

FILE: src/etr_front.sv
// front end: takes requests and classifies them into commands
module etr_front (
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // data_byte
    input  logic [2:0]    s_tuser,   // operation
    input  logic          q_full,
    output logic          q_push,
    output etr_pkg::cmd_t q_cmd
);
    import etr_pkg::*;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_cmd.data    = s_tdata;
        q_cmd.special = (s_tdata == FLAG_BYTE) || (s_tdata == ESC_BYTE);
        case (s_tuser)
            OP_BEGIN_FRAME: q_cmd.kind = CMD_BEGIN_ESC;
            OP_PAYLOAD:     q_cmd.kind = CMD_PAYLOAD;
            OP_END:         q_cmd.kind = CMD_END;
            OP_BEGIN_RAW:   q_cmd.kind = CMD_BEGIN_RAW;
            OP_TICK:        q_cmd.kind = CMD_TICK;
            default:        q_cmd.kind = CMD_NOP;
        endcase
    end

endmodule

FILE: src/etr_cmd_fifo.sv
// short command queue between front and back
module etr_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  etr_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output etr_pkg::cmd_t pop_cmd
);
    import etr_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);

    cmd_t          slot_reg [QUEUE_DEPTH];
    logic [QW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QW:0]   count_reg, count_next;

    assign full      = (count_reg == (QW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QW+1)'(push) - (QW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: src/etr_back.sv
// back end: ring memory, frame bookkeeping and result register
module etr_back #(
    parameter int RING_DEPTH = etr_pkg::RING_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  etr_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,   // out_byte
    output logic [3:0]    m_tuser    // out_valid, frame_status[1:0], ring_empty
);
    import etr_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WRITE = 3'b010,
        ST_READ  = 3'b100
    } state_t;

    logic [7:0] ring_mem [RING_DEPTH];

    state_t        state_reg, state_next;
    logic [AW-1:0] wr_head_reg, wr_head_next;
    logic [AW-1:0] rd_tail_reg, rd_tail_next;
    logic [AW-1:0] commit_head_reg, commit_head_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] pend_reg, pend_next;
    logic          open_reg, open_next;
    logic          ovf_reg, ovf_next;
    logic          raw_reg, raw_next;
    logic [7:0]    seq1_reg, seq1_next;
    logic [7:0]    seq2_reg, seq2_next;
    logic [1:0]    left_reg, left_next;
    logic          m_valid_reg, m_valid_next;
    logic          oflag_reg, oflag_next;
    frame_status_t status_reg, status_next;
    logic          empty_reg, empty_next;
    logic [7:0]    obyte_reg;

    logic          out_free;
    logic          mem_we, mem_re;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] head_inc, tail_inc;
    logic          first, esc, room_need, room_one;
    logic [1:0]    need;
    logic [7:0]    e0, e1, e2;

    assign out_free = !m_valid_reg || m_tready;
    assign head_inc = (wr_head_reg == AW'(RING_DEPTH - 1)) ? '0 : wr_head_reg + 1'b1;
    assign tail_inc = (rd_tail_reg == AW'(RING_DEPTH - 1)) ? '0 : rd_tail_reg + 1'b1;

    // entry sequence of one payload byte
    assign first = (pend_reg == '0) && !raw_reg;
    assign esc   = q_cmd.special && !raw_reg;
    assign need  = 2'(first) + 2'(esc) + 2'd1;
    assign e0    = first ? FLAG_BYTE : (esc ? ESC_BYTE : q_cmd.data);
    assign e1    = first ? (esc ? ESC_BYTE : q_cmd.data) : (q_cmd.data ^ ESC_XOR);
    assign e2    = q_cmd.data ^ ESC_XOR;

    assign room_need = ({1'b0, fill_reg} + (CW+1)'(need)) <= (CW+1)'(RING_DEPTH);
    assign room_one  = ({1'b0, fill_reg} + (CW+1)'(1)) <= (CW+1)'(RING_DEPTH);

    always_comb begin
        state_next       = state_reg;
        wr_head_next     = wr_head_reg;
        rd_tail_next     = rd_tail_reg;
        commit_head_next = commit_head_reg;
        fill_next        = fill_reg;
        pend_next        = pend_reg;
        open_next        = open_reg;
        ovf_next         = ovf_reg;
        raw_next         = raw_reg;
        seq1_next        = seq1_reg;
        seq2_next        = seq2_reg;
        left_next        = left_reg;
        m_valid_next     = m_tready ? 1'b0 : m_valid_reg;
        oflag_next       = oflag_reg;
        status_next      = status_reg;
        empty_next       = empty_reg;
        q_pop            = 1'b0;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_wdata        = seq1_reg;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop        = 1'b1;
                    m_valid_next = 1'b1;
                    oflag_next   = 1'b0;
                    status_next  = FS_NONE;
                    case (q_cmd.kind)
                        CMD_BEGIN_ESC, CMD_BEGIN_RAW: begin
                            if (open_reg) begin
                                wr_head_next = commit_head_reg;
                                fill_next    = fill_reg - pend_reg;
                            end
                            open_next = 1'b1;
                            raw_next  = (q_cmd.kind == CMD_BEGIN_RAW);
                            ovf_next  = 1'b0;
                            pend_next = '0;
                        end
                        CMD_PAYLOAD: begin
                            if (open_reg && !ovf_reg) begin
                                if (room_need) begin
                                    mem_we       = 1'b1;
                                    mem_wdata    = e0;
                                    wr_head_next = head_inc;
                                    fill_next    = fill_reg + CW'(need);
                                    pend_next    = pend_reg + CW'(need);
                                    if (need != 2'd1) begin
                                        seq1_next  = e1;
                                        seq2_next  = e2;
                                        left_next  = need - 2'd1;
                                        state_next = ST_WRITE;
                                    end
                                end else begin
                                    wr_head_next = commit_head_reg;
                                    fill_next    = fill_reg - pend_reg;
                                    pend_next    = '0;
                                    ovf_next     = 1'b1;
                                end
                            end
                        end
                        CMD_END: begin
                            if (open_reg) begin
                                if (ovf_reg) begin
                                    status_next = FS_DISCARD;
                                end else if (pend_reg == '0) begin
                                    status_next = FS_NONE;
                                end else if (raw_reg) begin
                                    status_next      = FS_COMMIT;
                                    commit_head_next = wr_head_reg;
                                    pend_next        = '0;
                                end else if (room_one) begin
                                    // closing flag
                                    mem_we           = 1'b1;
                                    mem_wdata        = FLAG_BYTE;
                                    wr_head_next     = head_inc;
                                    commit_head_next = head_inc;
                                    fill_next        = fill_reg + 1'b1;
                                    pend_next        = '0;
                                    status_next      = FS_COMMIT;
                                end else begin
                                    wr_head_next = commit_head_reg;
                                    fill_next    = fill_reg - pend_reg;
                                    pend_next    = '0;
                                    status_next  = FS_DISCARD;
                                end
                                open_next = 1'b0;
                                ovf_next  = 1'b0;
                            end
                        end
                        CMD_TICK: begin
                            if (fill_reg > pend_reg) begin
                                mem_re       = 1'b1;
                                rd_tail_next = tail_inc;
                                fill_next    = fill_reg - 1'b1;
                                oflag_next   = 1'b1;
                                // result shows once read data is in
                                m_valid_next = 1'b0;
                                state_next   = ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                    empty_next = !(fill_next > pend_next);
                end
            end
            ST_WRITE: begin
                mem_we       = 1'b1;
                mem_wdata    = seq1_reg;
                wr_head_next = head_inc;
                seq1_next    = seq2_reg;
                left_next    = left_reg - 2'd1;
                if (left_reg == 2'd1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            wr_head_reg     <= '0;
            rd_tail_reg     <= '0;
            commit_head_reg <= '0;
            fill_reg        <= '0;
            pend_reg        <= '0;
            open_reg        <= 1'b0;
            ovf_reg         <= 1'b0;
            raw_reg         <= 1'b0;
            left_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            wr_head_reg     <= wr_head_next;
            rd_tail_reg     <= rd_tail_next;
            commit_head_reg <= commit_head_next;
            fill_reg        <= fill_next;
            pend_reg        <= pend_next;
            open_reg        <= open_next;
            ovf_reg         <= ovf_next;
            raw_reg         <= raw_next;
            left_reg        <= left_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        seq1_reg   <= seq1_next;
        seq2_reg   <= seq2_next;
        oflag_reg  <= oflag_next;
        status_reg <= status_next;
        empty_reg  <= empty_next;
    end

    // single port ring: one write or one read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[wr_head_reg] <= mem_wdata;
        end
        if (mem_re) begin
            obyte_reg <= ring_mem[rd_tail_reg];
        end else if (q_pop) begin
            obyte_reg <= '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = obyte_reg;
    assign m_tuser  = {empty_reg, status_reg, oflag_reg};

endmodule

FILE: tb/tb_escaped_frame_tx_ring.sv
// self-checking testbench of the escaped frame transmitter ring: line byte predictor and scoreboard
module tb_escaped_frame_tx_ring;
    import etr_pkg::*;

    localparam int          RING_DEPTH   = RING_DEPTH_DEF;
    localparam int          RANDOM_ITEMS = 700;
    localparam int          MAX_REPORTS  = 10;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam logic [2:0]  OP_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic          sent;
        logic [7:0]    line_byte;
        frame_status_t status;
        logic          ring_empty;
    } line_result_t;

    // line byte predictor plus the queue of results still owed by the block
    class frame_ring_scoreboard;
        logic [7:0]   ring_mem [RING_DEPTH];
        int unsigned  wr_ptr, rd_ptr, commit_ptr, used, pending;
        bit           in_frame, raw_block, dropping;
        line_result_t expected_q [$];
        int unsigned  errors;

        function void flag_error(string what);
            if (errors < MAX_REPORTS) begin
                $display("%s", what);
            end
            errors++;
        endfunction

        function void put_entry(logic [7:0] v);
            ring_mem[wr_ptr] = v;
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
            used++;
            pending++;
        endfunction

        function void drop_pending();
            wr_ptr = commit_ptr;
            used -= pending;
            pending = 0;
        endfunction

        function bit room_for(int unsigned n);
            return used + n <= RING_DEPTH;
        endfunction

        function void note_request(logic [2:0] op, logic [7:0] data);
            line_result_t r;
            bit           esc;
            int unsigned  need;
            r = '0;
            case (op)
                OP_BEGIN_FRAME, OP_BEGIN_RAW: begin
                    // a begin while a frame is open drops it without a status
                    if (in_frame) begin
                        drop_pending();
                    end
                    in_frame  = 1'b1;
                    raw_block = (op == OP_BEGIN_RAW);
                    dropping  = 1'b0;
                    pending   = 0;
                end
                OP_PAYLOAD: if (in_frame && !dropping) begin
                    esc  = (data == FLAG_BYTE) || (data == ESC_BYTE);
                    // the opening flag goes in with the first byte and shares its room check
                    need = raw_block ? 1 : (pending == 0 ? 1 : 0) + (esc ? 2 : 1);
                    if (!room_for(need)) begin
                        drop_pending();
                        dropping = 1'b1;
                    end else if (raw_block) begin
                        put_entry(data);
                    end else begin
                        if (pending == 0) begin
                            put_entry(FLAG_BYTE);
                        end
                        if (esc) begin
                            put_entry(ESC_BYTE);
                            put_entry(data ^ ESC_XOR);
                        end else begin
                            put_entry(data);
                        end
                    end
                end
                OP_END: if (in_frame) begin
                    if (dropping) begin
                        r.status = FS_DISCARD;
                    end else if (pending == 0) begin
                        r.status = FS_NONE;
                    end else if (raw_block) begin
                        r.status = FS_COMMIT;
                    end else if (room_for(1)) begin
                        put_entry(FLAG_BYTE);
                        r.status = FS_COMMIT;
                    end else begin
                        drop_pending();
                        r.status = FS_DISCARD;
                    end
                    if (r.status == FS_COMMIT) begin
                        commit_ptr = wr_ptr;
                        pending    = 0;
                    end
                    in_frame = 1'b0;
                    dropping = 1'b0;
                end
                OP_TICK: if (used > pending) begin
                    r.sent      = 1'b1;
                    r.line_byte = ring_mem[rd_ptr];
                    rd_ptr      = (rd_ptr + 1) % RING_DEPTH;
                    used--;
                end
                default: ;
            endcase
            r.ring_empty = !(used > pending);
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [7:0] tdata, logic [3:0] tuser);
            line_result_t want, got;
            got.sent       = tuser[0];
            got.line_byte  = tdata;
            got.status     = frame_status_t'(tuser[2:1]);
            got.ring_empty = tuser[3];
            if (expected_q.size() == 0) begin
                flag_error($sformatf(
                    "unexpected result: sent=%0d byte=%02h status=%0d empty=%0d",
                    got.sent, got.line_byte, got.status, got.ring_empty));
                return;
            end
            want = expected_q.pop_front();
            if (got.sent !== want.sent || got.line_byte !== want.line_byte ||
                got.status !== want.status || got.ring_empty !== want.ring_empty) begin
                flag_error({
                    $sformatf("mismatch: expected sent=%0d byte=%02h status=%0d empty=%0d",
                              want.sent, want.line_byte, want.status, want.ring_empty),
                    $sformatf(", got sent=%0d byte=%02h status=%0d empty=%0d",
                              got.sent, got.line_byte, got.status, got.ring_empty)});
            end
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // data_byte
    logic [2:0] s_tuser;   // operation
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // out_byte
    logic [3:0] m_tuser;   // out_valid, frame_status[1:0], ring_empty

    frame_ring_scoreboard sb = new();
    bit          src_burst;
    bit          snk_burst;
    int unsigned sent_count;
    int unsigned cycle_count;

    escaped_frame_tx_ring #(.RING_DEPTH(RING_DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tuser);
        end
    end

    // result side: random stall before each result, with stretches of none
    initial begin
        int unsigned stall;
        m_tready = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if ($urandom_range(0, 49) == 0) begin
                snk_burst = !snk_burst;
            end
            stall = snk_burst ? 0 : $urandom_range(0, 11);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // payload leaning toward the flag and escape codes
    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 7))
            0:       return FLAG_BYTE;
            1:       return ESC_BYTE;
            default: return any_byte();
        endcase
    endfunction

    task automatic send_request(input logic [2:0] op, input logic [7:0] data);
        int unsigned gap;
        if ($urandom_range(0, 49) == 0) begin
            src_burst = !src_burst;
        end
        gap = src_burst ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, data);
        sent_count++;
    endtask

    task automatic tick_until_empty();
        while (sb.used > sb.pending) begin
            send_request(OP_TICK, any_byte());
        end
    endtask

    task automatic send_frame(input logic [2:0] begin_op, input int unsigned len,
                              input int unsigned tick_pct);
        send_request(begin_op, any_byte());
        repeat (len) begin
            if ($urandom_range(0, 99) < tick_pct) begin
                send_request(OP_TICK, any_byte());
            end
            send_request(OP_PAYLOAD, payload_byte());
        end
        send_request(OP_END, any_byte());
    endtask

    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.expected_q.size() != 0);
    endtask

    // ring filled to the last entry, then every way a frame can run out of room
    task automatic overfill_ring();
        pause_until_drained();
        tick_until_empty();
        send_request(OP_BEGIN_FRAME, any_byte());
        repeat ((RING_DEPTH - 2) / 2) begin
            send_request(OP_PAYLOAD, $urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE);
        end
        send_request(OP_END, any_byte());
        // raw block with no room, later payload ignored
        send_request(OP_BEGIN_RAW, any_byte());
        send_request(OP_PAYLOAD, any_byte());
        send_request(OP_PAYLOAD, any_byte());
        send_request(OP_END, any_byte());
        send_request(OP_BEGIN_FRAME, any_byte());
        send_request(OP_PAYLOAD, 8'h41);
        send_request(OP_END, any_byte());
        // one free entry: start flag fits alone but not with its byte
        send_request(OP_TICK, any_byte());
        send_request(OP_BEGIN_FRAME, any_byte());
        send_request(OP_PAYLOAD, 8'h41);
        send_request(OP_END, any_byte());
        // payload fills the ring exactly, closing flag has no room
        send_request(OP_TICK, any_byte());
        send_request(OP_TICK, any_byte());
        send_request(OP_BEGIN_FRAME, any_byte());
        send_request(OP_PAYLOAD, 8'h41);
        send_request(OP_PAYLOAD, 8'h42);
        send_request(OP_END, any_byte());
        send_request(OP_TICK, any_byte());
        send_request(OP_BEGIN_RAW, any_byte());
        send_request(OP_PAYLOAD, any_byte());
        send_request(OP_END, any_byte());
    endtask

    initial begin
        int unsigned target;
        int unsigned pick;
        bit          overfilled;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = OP_TICK;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // stray requests on an idle ring
        send_request(OP_TICK, 8'hFF);
        send_request(OP_PAYLOAD, 8'hA5);
        send_request(OP_END, 8'h00);
        send_request(OP_UNUSED_HI, 8'hFF);
        // empty frame
        send_request(OP_BEGIN_FRAME, 8'h00);
        send_request(OP_END, 8'h00);
        // raw block cut off by a new escaped frame
        send_request(OP_BEGIN_RAW, 8'h00);
        send_request(OP_PAYLOAD, FLAG_BYTE);
        send_request(OP_BEGIN_FRAME, 8'h00);
        send_request(OP_PAYLOAD, 8'h00);
        send_request(OP_PAYLOAD, 8'hFF);
        send_request(OP_PAYLOAD, FLAG_BYTE);
        send_request(OP_PAYLOAD, ESC_BYTE);
        send_request(OP_END, 8'h00);
        send_request(OP_BEGIN_RAW, 8'hFF);
        send_request(OP_PAYLOAD, ESC_BYTE);
        send_request(OP_PAYLOAD, 8'h80);
        send_request(OP_END, 8'hFF);
        tick_until_empty();
        send_request(OP_TICK, 8'h00);

        target     = sent_count + RANDOM_ITEMS;
        overfilled = 1'b0;
        while (sent_count < target) begin
            // full ring first, the random mix then drains it
            if (!overfilled) begin
                overfill_ring();
                overfilled = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                send_frame($urandom_range(0, 9) < 7 ? OP_BEGIN_FRAME : OP_BEGIN_RAW,
                           $urandom_range(0, 14) == 0 ? $urandom_range(40, 120)
                                                      : $urandom_range(0, 12),
                           25);
            end else if (pick < 88) begin
                // drain harder once the ring is half full
                repeat (sb.used > RING_DEPTH / 2 ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 8)) begin
                    send_request(OP_TICK, any_byte());
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_request(3'($urandom_range(0, 7)), payload_byte());
                end
            end
        end

        pause_until_drained();
        repeat (16) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
